// ===== rtl/core/hilbert_cell_stroke_distance_core_macros.svh =====
// ---------------------------------------------------------------------------
// hilbert cell stroke distance core assertion macros
// shared concurrent assertion forms, clocked on clk with rst_n as disable
// ---------------------------------------------------------------------------
`ifndef HILBERT_CELL_STROKE_DISTANCE_CORE_MACROS_SVH
`define HILBERT_CELL_STROKE_DISTANCE_CORE_MACROS_SVH

// condition holds at every clock edge out of reset
`define HCSD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define HCSD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hcsd_pkg.sv =====
// ---------------------------------------------------------------------------
// hcsd_pkg
// shared types, constants and helpers of the hilbert cell stroke distance core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcsd_pkg;

    // field widths
    localparam int CELL_W  = 3;
    localparam int FRAC_W  = 8;
    localparam int DIST_W  = 8;
    localparam int INDEX_W = 6;
    localparam int LINK_W  = 4;

    // cell centre in 1/256 cell
    localparam logic [FRAC_W:0] CENTRE = 9'd128;

    // link mask bit positions
    localparam int LINK_PX = 0;
    localparam int LINK_MX = 1;
    localparam int LINK_PY = 2;
    localparam int LINK_MY = 3;

    // square root working width and digit weights, one per step
    localparam int SQ_W      = 16;
    localparam int ISQ_STEPS = 8;
    localparam logic [SQ_W-1:0] ISQ_BIT [ISQ_STEPS] = '{
        16'h4000, 16'h1000, 16'h0400, 16'h0100,
        16'h0040, 16'h0010, 16'h0004, 16'h0001
    };

    // partial square root: remaining value and root so far
    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] r;
    } isq_t;

    // point offset from centre, magnitudes and sides
    typedef struct packed {
        logic [FRAC_W-1:0] aex;
        logic [FRAC_W-1:0] aey;
        logic              ex_pos;
        logic              ex_neg;
        logic              ey_pos;
        logic              ey_neg;
    } geo_t;

    // data that rides beside the square root stages
    typedef struct packed {
        geo_t               geo;
        logic [LINK_W-1:0]  mask;
        logic [INDEX_W-1:0] idx;
    } side_t;

    // quadrant contribution of one curve level: (3 * rx) ^ ry
    function automatic logic [1:0] quad_code(input logic rx, input logic ry);
        return {rx, rx ^ ry};
    endfunction

    // one digit step of the restoring integer square root
    function automatic isq_t isq_step(input isq_t s, input logic [SQ_W-1:0] b);
        logic [SQ_W:0] trial;
        isq_t          n;
        trial = {1'b0, s.r} + {1'b0, b};
        if ({1'b0, s.v} >= trial)
        begin
            n.v = s.v - trial[SQ_W-1:0];
            n.r = (s.r >> 1) + b;
        end
        else
        begin
            n.v = s.v;
            n.r = s.r >> 1;
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/hcsd_xy2d.sv =====
// ---------------------------------------------------------------------------
// hcsd_xy2d
// hilbert curve index of one cell, reflections over the full tile
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcsd_xy2d
    import hcsd_pkg::*;
#(
    parameter int CURVE_ORDER = 3
)
(
    input  logic [CURVE_ORDER-1:0]   x,
    input  logic [CURVE_ORDER-1:0]   y,
    output logic [2*CURVE_ORDER-1:0] d
);

    logic [CURVE_ORDER-1:0] xw;
    logic [CURVE_ORDER-1:0] yw;
    logic [CURVE_ORDER-1:0] tw;
    logic                   rx;
    logic                   ry;

    // walk the levels from the top, rotating the lower bits as we go
    always_comb
    begin
        d  = '0;
        xw = x;
        yw = y;
        tw = '0;
        rx = 1'b0;
        ry = 1'b0;
        for (int i = CURVE_ORDER - 1; i >= 0; i--)
        begin
            rx = xw[i];
            ry = yw[i];
            d[2*i +: 2] = quad_code(rx, ry);
            if (!ry)
            begin
                if (rx)
                begin
                    xw = ~xw;
                    yw = ~yw;
                end
                tw = xw;
                xw = yw;
                yw = tw;
            end
        end
    end

endmodule

// ===== rtl/core/hilbert_cell_stroke_distance_core.sv =====
// ---------------------------------------------------------------------------
// hilbert_cell_stroke_distance_core
// curve index, curve links and stroke distance, when not stalled, for one cell point per clock
// ---------------------------------------------------------------------------
// Takes one request per clock unless every stage is full and the output is
// stalled, and returns one result per request, in order. The pipeline depth
// is six register stages: the first stage squares the centre offsets and
// computes the curve index of the cell and of its four neighbours, four
// stages each run two digit steps of the integer square root (the link test
// sits in the first of them), and the last stage picks the nearest stroke
// part into the output register. Every stage holds its own valid bit and
// moves on whenever the stage after it is empty or moving, so a stalled
// output only holds back the stages behind it.
`timescale 1ns / 1ps

`include "hilbert_cell_stroke_distance_core_macros.svh"

module hilbert_cell_stroke_distance_core
    import hcsd_pkg::*;
#(
    parameter int CURVE_ORDER = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cell_x[2:0], cell_y[5:3], frac_x[13:6], frac_y[21:14], zero fill
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // stroke_distance[7:0], curve_index[13:8], link_mask[17:14], zero fill
    output logic [23:0] m_tdata
);

    localparam int CW = CURVE_ORDER;
    localparam int IW = 2 * CURVE_ORDER;

    // ------------------------------------------------------------------
    // input fields
    // ------------------------------------------------------------------
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic [FRAC_W-1:0] frac_x;
    logic [FRAC_W-1:0] frac_y;

    assign cell_x = s_tdata[2:0];
    assign cell_y = s_tdata[5:3];
    assign frac_x = s_tdata[13:6];
    assign frac_y = s_tdata[21:14];

    // ------------------------------------------------------------------
    // stage handshake chain
    // ------------------------------------------------------------------
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic v5_reg;
    logic v6_reg;
    logic rdy2;
    logic rdy3;
    logic rdy4;
    logic rdy5;
    logic rdy6;

    assign rdy6     = !v6_reg || m_tready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign s_tready = !v1_reg || rdy2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                v1_reg <= s_tvalid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
            if (rdy6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: offsets, squares, cell and neighbour curve indexes
    // ------------------------------------------------------------------
    logic [CW+CELL_W-1:0] cx_wide;
    logic [CW+CELL_W-1:0] cy_wide;
    logic [CW-1:0]        cx;
    logic [CW-1:0]        cy;
    logic [CW:0]          cx_inc;
    logic [CW:0]          cy_inc;
    logic [CW-1:0]        cx_dec;
    logic [CW-1:0]        cy_dec;
    logic [FRAC_W:0]      ex;
    logic [FRAC_W:0]      ey;
    logic [FRAC_W:0]      ex_mag;
    logic [FRAC_W:0]      ey_mag;
    logic [SQ_W-1:0]      aex_ext;
    logic [SQ_W-1:0]      aey_ext;
    geo_t                 geo1_next;
    logic [SQ_W-1:0]      sum1_next;
    logic [3:0]           nb_next;
    logic [IW-1:0]        d0_next;
    logic [IW-1:0]        dn_next [4];

    assign cx_wide = {{CW{1'b0}}, cell_x};
    assign cy_wide = {{CW{1'b0}}, cell_y};
    assign cx      = cx_wide[CW-1:0];
    assign cy      = cy_wide[CW-1:0];
    assign cx_inc  = {1'b0, cx} + (CW+1)'(1);
    assign cy_inc  = {1'b0, cy} + (CW+1)'(1);
    assign cx_dec  = cx - CW'(1);
    assign cy_dec  = cy - CW'(1);

    // neighbours inside the tile
    assign nb_next[LINK_PX] = !cx_inc[CW];
    assign nb_next[LINK_MX] = (cx != '0);
    assign nb_next[LINK_PY] = !cy_inc[CW];
    assign nb_next[LINK_MY] = (cy != '0);

    hcsd_xy2d #(.CURVE_ORDER(CURVE_ORDER)) u_xy2d_c
    (
        .x (cx),
        .y (cy),
        .d (d0_next)
    );

    hcsd_xy2d #(.CURVE_ORDER(CURVE_ORDER)) u_xy2d_px
    (
        .x (cx_inc[CW-1:0]),
        .y (cy),
        .d (dn_next[LINK_PX])
    );

    hcsd_xy2d #(.CURVE_ORDER(CURVE_ORDER)) u_xy2d_mx
    (
        .x (cx_dec),
        .y (cy),
        .d (dn_next[LINK_MX])
    );

    hcsd_xy2d #(.CURVE_ORDER(CURVE_ORDER)) u_xy2d_py
    (
        .x (cx),
        .y (cy_inc[CW-1:0]),
        .d (dn_next[LINK_PY])
    );

    hcsd_xy2d #(.CURVE_ORDER(CURVE_ORDER)) u_xy2d_my
    (
        .x (cx),
        .y (cy_dec),
        .d (dn_next[LINK_MY])
    );

    // signed offsets from the centre and their magnitudes
    always_comb
    begin
        ex     = {1'b0, frac_x} - CENTRE;
        ey     = {1'b0, frac_y} - CENTRE;
        ex_mag = ex[FRAC_W] ? (~ex + (FRAC_W+1)'(1)) : ex;
        ey_mag = ey[FRAC_W] ? (~ey + (FRAC_W+1)'(1)) : ey;
        geo1_next.aex    = ex_mag[FRAC_W-1:0];
        geo1_next.aey    = ey_mag[FRAC_W-1:0];
        geo1_next.ex_pos = !ex[FRAC_W] && (ex != '0);
        geo1_next.ex_neg = ex[FRAC_W];
        geo1_next.ey_pos = !ey[FRAC_W] && (ey != '0);
        geo1_next.ey_neg = ey[FRAC_W];
        // squares at full root width, the sum peaks at 32768
        aex_ext   = {{(SQ_W-FRAC_W){1'b0}}, geo1_next.aex};
        aey_ext   = {{(SQ_W-FRAC_W){1'b0}}, geo1_next.aey};
        sum1_next = aex_ext * aex_ext + aey_ext * aey_ext;
    end

    geo_t            geo1_reg;
    logic [SQ_W-1:0] sum1_reg;
    logic [3:0]      nb1_reg;
    logic [IW-1:0]   d01_reg;
    logic [IW-1:0]   dn1_reg [4];

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            geo1_reg <= geo1_next;
            sum1_reg <= sum1_next;
            nb1_reg  <= nb_next;
            d01_reg  <= d0_next;
            for (int k = 0; k < 4; k++)
            begin
                dn1_reg[k] <= dn_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: link test, root digits one and two
    // ------------------------------------------------------------------
    logic [IW+INDEX_W-1:0] d0_wide;
    logic [IW:0]           d0_inc;
    logic [IW:0]           dn_inc [4];
    side_t                 side2_next;
    isq_t                  isq_in;

    assign d0_wide = {{INDEX_W{1'b0}}, d01_reg};
    assign d0_inc  = {1'b0, d01_reg} + (IW+1)'(1);
    assign isq_in  = '{v: sum1_reg, r: '0};

    always_comb
    begin
        side2_next.geo = geo1_reg;
        side2_next.idx = d0_wide[INDEX_W-1:0];
        for (int k = 0; k < 4; k++)
        begin
            dn_inc[k] = {1'b0, dn1_reg[k]} + (IW+1)'(1);
            side2_next.mask[k] = nb1_reg[k]
                && ((d0_inc == {1'b0, dn1_reg[k]}) || (dn_inc[k] == {1'b0, d01_reg}));
        end
    end

    side_t side2_reg;
    isq_t  isq2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            side2_reg <= side2_next;
            isq2_reg  <= isq_step(isq_step(isq_in, ISQ_BIT[0]), ISQ_BIT[1]);
        end
    end

    // ------------------------------------------------------------------
    // stages 3 to 5: remaining root digits, two per stage
    // ------------------------------------------------------------------
    side_t side3_reg;
    side_t side4_reg;
    side_t side5_reg;
    isq_t  isq3_reg;
    isq_t  isq4_reg;
    isq_t  isq5_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            side3_reg <= side2_reg;
            isq3_reg  <= isq_step(isq_step(isq2_reg, ISQ_BIT[2]), ISQ_BIT[3]);
        end
        if (rdy4)
        begin
            side4_reg <= side3_reg;
            isq4_reg  <= isq_step(isq_step(isq3_reg, ISQ_BIT[4]), ISQ_BIT[5]);
        end
        if (rdy5)
        begin
            side5_reg <= side4_reg;
            isq5_reg  <= isq_step(isq_step(isq4_reg, ISQ_BIT[6]), ISQ_BIT[7]);
        end
    end

    // ------------------------------------------------------------------
    // stage 6: nearest of centre dot and linked arms
    // ------------------------------------------------------------------
    logic [DIST_W-1:0] best;

    always_comb
    begin
        best = isq5_reg.r[DIST_W-1:0];
        if (side5_reg.mask[LINK_PX] && side5_reg.geo.ex_pos && (side5_reg.geo.aey < best))
        begin
            best = side5_reg.geo.aey;
        end
        if (side5_reg.mask[LINK_MX] && side5_reg.geo.ex_neg && (side5_reg.geo.aey < best))
        begin
            best = side5_reg.geo.aey;
        end
        if (side5_reg.mask[LINK_PY] && side5_reg.geo.ey_pos && (side5_reg.geo.aex < best))
        begin
            best = side5_reg.geo.aex;
        end
        if (side5_reg.mask[LINK_MY] && side5_reg.geo.ey_neg && (side5_reg.geo.aex < best))
        begin
            best = side5_reg.geo.aex;
        end
    end

    logic [DIST_W-1:0]  dist6_reg;
    logic [INDEX_W-1:0] idx6_reg;
    logic [LINK_W-1:0]  mask6_reg;

    always_ff @(posedge clk)
    begin
        if (rdy6)
        begin
            dist6_reg <= best;
            idx6_reg  <= side5_reg.idx;
            mask6_reg <= side5_reg.mask;
        end
    end

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    assign m_tvalid = v6_reg;
    assign m_tdata  = {6'b0, mask6_reg, idx6_reg, dist6_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `HCSD_ASSERT_IMPLIES(a_dist_range, m_tvalid, (dist6_reg <= 8'd181), "distance above 181")
    `HCSD_ASSERT_IMPLIES(a_link_count, m_tvalid,
        (($countones(mask6_reg) >= 1) && ($countones(mask6_reg) <= 2)),
        "cell not linked to one or two neighbours")
    `HCSD_ASSERT_IMPLIES(a_full_on_stall, !s_tready,
        (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && v6_reg),
        "input held back with a free stage")

endmodule

// ===== dv/hilbert_cell_stroke_distance_core_test.sv =====
// ---------------------------------------------------------------------------
// hilbert_cell_stroke_distance_core_test
// self-checking bench for the hilbert cell stroke distance core
// ---------------------------------------------------------------------------
// A short table of corner points (tile corners, point extremes, points on
// the centre lines and on the arms) is streamed in first. Random cells and
// points follow, biased toward the centre lines and the extremes. Save for
// known directed rows, every accepted request gets its expected curve index,
// link mask and stroke distance from a behavioral model of the curve and the
// stroke, and results are checked in order. Both stream sides stall at random,
// one side heavily and then the other, and the last stretch runs with no stalls.
`timescale 1ns / 1ps

module hilbert_cell_stroke_distance_core_test;
    import hcsd_pkg::*;

    localparam int CURVE_ORDER    = 3;
    localparam int GRID_SIZE      = 1 << CURVE_ORDER;
    localparam int DIR_ROWS       = 22;
    localparam int RAND_PER_PHASE = 143;
    localparam int DRAIN_CYCLES   = 24;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int REPORT_MAX     = 10;

    // one request: a cell of the tile and a point inside it
    typedef struct packed {
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
        logic [FRAC_W-1:0] frac_x;
        logic [FRAC_W-1:0] frac_y;
    } cell_point_t;

    // one result
    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [INDEX_W-1:0] idx;
        logic [LINK_W-1:0]  mask;
    } stroke_t;

    // directed row, with a typed-in result where known is set
    typedef struct packed {
        cell_point_t pt;
        logic        known;
        stroke_t     res;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // cell_x[2:0], cell_y[5:3], frac_x[13:6], frac_y[21:14], zero fill
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // stroke_distance[7:0], curve_index[13:8], link_mask[17:14], zero fill
    logic [23:0] m_tdata;

    stroke_t     stroke_due [$];
    dir_row_t    dir_table [DIR_ROWS];
    int          mismatch_count = 0;
    int          send_gap_pct = 0;
    int          take_gap_pct = 0;
    int unsigned cycle_count = 0;

    hilbert_cell_stroke_distance_core #(
        .CURVE_ORDER (CURVE_ORDER)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // position of a cell along the curve, reflection over the full tile
    function automatic int unsigned curve_rank(input int unsigned col, input int unsigned row);
        int unsigned rank;
        int unsigned half;
        int unsigned qx;
        int unsigned qy;
        int unsigned tmp;
        rank = 0;
        for (half = GRID_SIZE / 2; half > 0; half = half / 2)
        begin
            qx = (col & half) != 0;
            qy = (row & half) != 0;
            rank += half * half * ((3 * qx) ^ qy);
            if (qy == 0)
            begin
                if (qx != 0)
                begin
                    col = GRID_SIZE - 1 - col;
                    row = GRID_SIZE - 1 - row;
                end
                tmp = col;
                col = row;
                row = tmp;
            end
        end
        return rank;
    endfunction

    function automatic bit curve_adjacent(input int unsigned a, input int unsigned b);
        return (a == b + 1) || (b == a + 1);
    endfunction

    function automatic int unsigned root_floor(input int unsigned v);
        int unsigned r;
        r = 0;
        while ((r + 1) * (r + 1) <= v)
            r++;
        return r;
    endfunction

    // curve index, links and nearest stroke part for one point
    function automatic stroke_t predict_stroke(input cell_point_t pt);
        int unsigned cx;
        int unsigned cy;
        int unsigned here;
        int          ex;
        int          ey;
        int unsigned aex;
        int unsigned aey;
        int unsigned nearest;
        logic [LINK_W-1:0] links;
        stroke_t     res;
        cx = pt.cell_x & (GRID_SIZE - 1);
        cy = pt.cell_y & (GRID_SIZE - 1);
        ex = int'(pt.frac_x) - int'(CENTRE);
        ey = int'(pt.frac_y) - int'(CENTRE);
        aex = (ex < 0) ? -ex : ex;
        aey = (ey < 0) ? -ey : ey;
        here = curve_rank(cx, cy);
        nearest = root_floor(aex * aex + aey * aey);
        links = '0;
        // each arm only counts on its own side of the centre
        if (cx + 1 < GRID_SIZE && curve_adjacent(curve_rank(cx + 1, cy), here))
        begin
            links[LINK_PX] = 1'b1;
            if (ex > 0 && aey < nearest)
                nearest = aey;
        end
        if (cx > 0 && curve_adjacent(curve_rank(cx - 1, cy), here))
        begin
            links[LINK_MX] = 1'b1;
            if (ex < 0 && aey < nearest)
                nearest = aey;
        end
        if (cy + 1 < GRID_SIZE && curve_adjacent(curve_rank(cx, cy + 1), here))
        begin
            links[LINK_PY] = 1'b1;
            if (ey > 0 && aex < nearest)
                nearest = aex;
        end
        if (cy > 0 && curve_adjacent(curve_rank(cx, cy - 1), here))
        begin
            links[LINK_MY] = 1'b1;
            if (ey < 0 && aex < nearest)
                nearest = aex;
        end
        res.distance = nearest[DIST_W-1:0];
        res.idx      = here[INDEX_W-1:0];
        res.mask     = links;
        return res;
    endfunction

    // point coordinate, leaning toward the centre line and the edges
    function automatic logic [FRAC_W-1:0] pick_frac();
        int v;
        case ($urandom_range(7))
            0: v = int'(CENTRE);
            1: v = int'(CENTRE) + int'($urandom_range(6)) - 3;
            2: v = ($urandom_range(1) != 0) ? 255 : 0;
            default: v = $urandom_range(255);
        endcase
        return v[FRAC_W-1:0];
    endfunction

    // offer one request, with random gaps ahead of it
    task automatic offer_point(input cell_point_t pt, input stroke_t res);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, pt.frac_y, pt.frac_x, pt.cell_y, pt.cell_x};
        do
            @(posedge clk);
        while (!s_tready);
        stroke_due.push_back(res);
    endtask

    // compare one result with the oldest expectation
    task automatic check_stroke(input logic [23:0] word);
        stroke_t got;
        stroke_t want;
        got.distance = word[7:0];
        got.idx      = word[13:8];
        got.mask     = word[17:14];
        if (stroke_due.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("unexpected result: dist %0d idx %0d mask %b",
                         got.distance, got.idx, got.mask);
        end
        else
        begin
            want = stroke_due.pop_front();
            if (got.distance !== want.distance || got.idx !== want.idx
                || got.mask !== want.mask)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display({"mismatch: expected dist %0d idx %0d mask %b,",
                              " got dist %0d idx %0d mask %b"},
                             want.distance, want.idx, want.mask,
                             got.distance, got.idx, got.mask);
            end
        end
    endtask

    // result side: check accepted results, then stall at random
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_stroke(m_tdata);
        m_tready <= ($urandom_range(99) >= take_gap_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        cell_point_t pt;
        int          phase;
        int          n;

        // cell x, cell y, point x, point y, known, distance, index, links
        dir_table = '{
            '{'{3'd0, 3'd0, 8'd128, 8'd128}, 1'b1, '{8'd0,   6'd0, 4'b0100}},
            '{'{3'd0, 3'd0, 8'd0,   8'd0},   1'b1, '{8'd181, 6'd0, 4'b0100}},
            '{'{3'd0, 3'd0, 8'd255, 8'd255}, 1'b0, '0},
            '{'{3'd7, 3'd7, 8'd255, 8'd0},   1'b0, '0},
            '{'{3'd7, 3'd0, 8'd0,   8'd255}, 1'b0, '0},
            '{'{3'd0, 3'd7, 8'd255, 8'd255}, 1'b0, '0},
            '{'{3'd3, 3'd4, 8'd128, 8'd0},   1'b0, '0},
            '{'{3'd4, 3'd3, 8'd0,   8'd128}, 1'b0, '0},
            '{'{3'd1, 3'd1, 8'd200, 8'd128}, 1'b0, '0},
            '{'{3'd2, 3'd5, 8'd40,  8'd128}, 1'b0, '0},
            '{'{3'd5, 3'd2, 8'd128, 8'd220}, 1'b0, '0},
            '{'{3'd6, 3'd6, 8'd128, 8'd30},  1'b0, '0},
            '{'{3'd3, 3'd3, 8'd128, 8'd255}, 1'b0, '0},
            '{'{3'd4, 3'd4, 8'd255, 8'd128}, 1'b0, '0},
            '{'{3'd1, 3'd6, 8'd129, 8'd127}, 1'b0, '0},
            '{'{3'd6, 3'd1, 8'd127, 8'd129}, 1'b0, '0},
            '{'{3'd2, 3'd2, 8'd170, 8'd10},  1'b0, '0},
            '{'{3'd5, 3'd5, 8'd10,  8'd170}, 1'b0, '0},
            '{'{3'd7, 3'd3, 8'd240, 8'd128}, 1'b0, '0},
            '{'{3'd0, 3'd4, 8'd16,  8'd128}, 1'b0, '0},
            '{'{3'd3, 3'd0, 8'd128, 8'd250}, 1'b0, '0},
            '{'{3'd4, 3'd7, 8'd128, 8'd5},   1'b0, '0}
        };

        // reset
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < 3; phase++)
        begin
            // light sender gaps with heavy result stalls, then swapped, then none
            case (phase)
                0:
                begin
                    send_gap_pct = 6;
                    take_gap_pct = 77;
                end
                1:
                begin
                    send_gap_pct = 77;
                    take_gap_pct = 6;
                end
                default:
                begin
                    send_gap_pct = 0;
                    take_gap_pct = 0;
                end
            endcase

            // directed corner points
            if (phase == 0)
            begin
                for (n = 0; n < DIR_ROWS; n++)
                begin
                    if (dir_table[n].known)
                        offer_point(dir_table[n].pt, dir_table[n].res);
                    else
                        offer_point(dir_table[n].pt, predict_stroke(dir_table[n].pt));
                end
            end

            // random cells and points
            for (n = 0; n < RAND_PER_PHASE; n++)
            begin
                pt.cell_x = $urandom_range(7);
                pt.cell_y = $urandom_range(7);
                pt.frac_x = pick_frac();
                pt.frac_y = pick_frac();
                offer_point(pt, predict_stroke(pt));
            end
        end
        s_tvalid <= 1'b0;

        // drain
        while (stroke_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && stroke_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
